// ----- design/msc_pkg.sv -----
package msc_pkg;

    // Servo count and storage slots
    localparam int NUM_SERVOS = 6;
    localparam int SLOTS      = 6;

    // Field widths
    localparam int FUNC_W    = 3;
    localparam int IDX_W     = 3;
    localparam int ANGLE_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int CHAN_W    = 4;
    localparam int PULSE_W   = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    // Pulse arithmetic widths
    localparam int SPAN_W  = PULSE_W + 1;
    localparam int PROD_W  = 22;
    localparam int MAG_W   = 20;
    localparam int QUOT_W  = 13;
    localparam int SUM_W   = 15;

    // Divide by full scale through a scaled reciprocal, exact for MAG_W-bit values
    localparam int FULL_SCALE_DEG = 180;
    localparam int DIV_SHIFT      = 28;
    localparam int RECIP_W        = 21;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + FULL_SCALE_DEG - 1) / FULL_SCALE_DEG;
    localparam int MULT_W = MAG_W + RECIP_W;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_GO_MIN    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GO_MAX    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_ANGLE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ANGLE = 2'd2;

    // Result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_PULSE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_ANGLES  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ANGLES  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_MAP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_MIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_MAX   = 3'd4;

    // Configuration reset values
    localparam logic [SLOTS*ANGLE_W-1:0] MIN_ANGLES_RST  = 48'd65971872081925;
    localparam logic [SLOTS*ANGLE_W-1:0] MAX_ANGLES_RST  = 48'd127219959764645;
    localparam logic [SLOTS*CHAN_W-1:0]  CHANNEL_MAP_RST = 24'd12355376;
    localparam logic [PULSE_W-1:0]       PULSE_MIN_RST   = 12'd600;
    localparam logic [PULSE_W-1:0]       PULSE_MAX_RST   = 12'd2500;

    // Angle reset values
    localparam logic [ANGLE_W-1:0] RESET_ANGLE [SLOTS] =
        '{8'd90, 8'd90, 8'd90, 8'd90, 8'd90, 8'd80};

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [IDX_W-1:0]   servo_index;
        logic [ANGLE_W-1:0] target_angle;
        logic               angle_valid;
    } req_t;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   channel;
        logic [PULSE_W-1:0]  pulse_us;
        logic                last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic do_ack;
        logic do_scan;
        logic do_step;
        logic do_mul;
        logic do_emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_cmd;
        logic in_is_tick;
        logic scan_none;
        logic out_free;
        logic last_move;
    } dp_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACK  = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_STEP = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

endpackage

// ----- design/multi_servo_slew_controller_unit.sv -----
// Channel  Ports                            Carries
// -------  -------------------------------  ------------------------------------
// input    s_valid, s_ready, s_data         command or tick request (req_t)
// output   m_valid, m_ready, m_data         acknowledgement or pulse update (rsp_t)
// config   cfg_we, cfg_addr, cfg_wdata      limits, channel map, pulse range
//
// A command passes through the acknowledge state, which loads its acknowledgement into the
// output register once that register is free.
// A tick scans, going idle if no servo moves; otherwise each moving servo passes through step,
// reciprocal multiply and emit; the shared multiply path handles one servo at a time.
// One request is worked at a time; the input is ready again once the last result is loaded.
// A stalled output holds the controller in its acknowledge or emit state.
// Reset restores limits, channels, pulse range and all angles at once; no clearing pass.
module multi_servo_slew_controller_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [msc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [msc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  msc_pkg::req_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output msc_pkg::rsp_t                    m_data
);

    msc_pkg::ctrl_cmd_t cmd;
    msc_pkg::dp_stat_t  stat;

    // Sequencer
    msc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Angle state, pulse arithmetic and output register
    msc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- design/msc_datapath.sv -----
module msc_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [msc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [msc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  msc_pkg::req_t                    s_data,
    input  logic                             m_ready,
    output logic                             m_valid,
    output msc_pkg::rsp_t                    m_data,
    input  msc_pkg::ctrl_cmd_t               cmd,
    output msc_pkg::dp_stat_t                stat
);

    // Configuration registers
    logic [msc_pkg::SLOTS*msc_pkg::ANGLE_W-1:0] min_angles_reg;
    logic [msc_pkg::SLOTS*msc_pkg::ANGLE_W-1:0] max_angles_reg;
    logic [msc_pkg::SLOTS*msc_pkg::CHAN_W-1:0]  channel_map_reg;
    logic [msc_pkg::PULSE_W-1:0]                pulse_min_reg;
    logic [msc_pkg::PULSE_W-1:0]                pulse_max_reg;

    // Servo state
    logic [msc_pkg::ANGLE_W-1:0] cur_angle_reg [msc_pkg::SLOTS];
    logic [msc_pkg::ANGLE_W-1:0] tgt_angle_reg [msc_pkg::SLOTS];

    // Work registers
    msc_pkg::req_t                     req_reg;
    logic [msc_pkg::IDX_W-1:0]         idx_reg;
    logic [msc_pkg::SLOTS-1:0]         mask_reg;
    logic signed [msc_pkg::PROD_W-1:0] prod_reg;
    logic [msc_pkg::QUOT_W-1:0]        quot_reg;
    logic                              neg_reg;
    logic                              out_valid_reg;
    msc_pkg::rsp_t                     out_data_reg;

    logic [msc_pkg::ANGLE_W-1:0]       sel_cur;
    logic [msc_pkg::ANGLE_W-1:0]       sel_tgt;
    logic [msc_pkg::ANGLE_W-1:0]       sel_lo;
    logic [msc_pkg::ANGLE_W-1:0]       sel_hi;
    logic [msc_pkg::CHAN_W-1:0]        sel_chan;
    logic                              idx_ok;
    logic [msc_pkg::SLOTS-1:0]         scan_mask;
    logic [msc_pkg::SLOTS-1:0]         mask_clr;
    logic [msc_pkg::ANGLE_W-1:0]       step_ang;
    logic signed [msc_pkg::SPAN_W-1:0] span;
    logic signed [msc_pkg::PROD_W-1:0] step_prod;
    logic signed [msc_pkg::PROD_W-1:0] prod_abs;
    logic [msc_pkg::MULT_W-1:0]        recip_prod;
    logic signed [msc_pkg::SUM_W-1:0]  quot_signed;
    logic signed [msc_pkg::SUM_W-1:0]  pulse_sum;
    logic [msc_pkg::PULSE_W-1:0]       pulse_sat;
    logic [msc_pkg::STATUS_W-1:0]      ack_status;
    logic                              ack_wr;
    logic [msc_pkg::ANGLE_W-1:0]       ack_val;
    logic                              out_free;
    logic                              out_load;
    msc_pkg::rsp_t                     out_data_next;
    logic                              out_valid_next;

    // Lowest servo still marked to move
    function automatic logic [msc_pkg::IDX_W-1:0] first_set(
        input logic [msc_pkg::SLOTS-1:0] m
    );
        logic [msc_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = msc_pkg::SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = msc_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angles_reg  <= msc_pkg::MIN_ANGLES_RST;
            max_angles_reg  <= msc_pkg::MAX_ANGLES_RST;
            channel_map_reg <= msc_pkg::CHANNEL_MAP_RST;
            pulse_min_reg   <= msc_pkg::PULSE_MIN_RST;
            pulse_max_reg   <= msc_pkg::PULSE_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                msc_pkg::CFG_MIN_ANGLES: begin
                    min_angles_reg <= cfg_wdata[msc_pkg::SLOTS*msc_pkg::ANGLE_W-1:0];
                end
                msc_pkg::CFG_MAX_ANGLES: begin
                    max_angles_reg <= cfg_wdata[msc_pkg::SLOTS*msc_pkg::ANGLE_W-1:0];
                end
                msc_pkg::CFG_CHANNEL_MAP: begin
                    channel_map_reg <= cfg_wdata[msc_pkg::SLOTS*msc_pkg::CHAN_W-1:0];
                end
                msc_pkg::CFG_PULSE_MIN: begin
                    pulse_min_reg <= cfg_wdata[msc_pkg::PULSE_W-1:0];
                end
                msc_pkg::CFG_PULSE_MAX: begin
                    pulse_max_reg <= cfg_wdata[msc_pkg::PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Select the addressed servo
    always_comb begin
        sel_cur  = cur_angle_reg[idx_reg];
        sel_tgt  = tgt_angle_reg[idx_reg];
        sel_lo   = min_angles_reg[idx_reg*msc_pkg::ANGLE_W +: msc_pkg::ANGLE_W];
        sel_hi   = max_angles_reg[idx_reg*msc_pkg::ANGLE_W +: msc_pkg::ANGLE_W];
        sel_chan = channel_map_reg[idx_reg*msc_pkg::CHAN_W +: msc_pkg::CHAN_W];
        idx_ok   = idx_reg < msc_pkg::IDX_W'(msc_pkg::NUM_SERVOS);
    end

    // Mark every servo that moves on this tick
    always_comb begin
        logic [msc_pkg::ANGLE_W-1:0] lo;
        logic [msc_pkg::ANGLE_W-1:0] hi;
        for (int i = 0; i < msc_pkg::SLOTS; i++) begin
            lo = min_angles_reg[i*msc_pkg::ANGLE_W +: msc_pkg::ANGLE_W];
            hi = max_angles_reg[i*msc_pkg::ANGLE_W +: msc_pkg::ANGLE_W];
            scan_mask[i] = (i < msc_pkg::NUM_SERVOS) &&
                (((tgt_angle_reg[i] > cur_angle_reg[i]) && (cur_angle_reg[i] < hi)) ||
                 ((tgt_angle_reg[i] < cur_angle_reg[i]) && (cur_angle_reg[i] > lo)));
        end
    end

    // Drop the servo just emitted
    always_comb begin
        mask_clr          = mask_reg;
        mask_clr[idx_reg] = 1'b0;
    end

    // Step one degree and scale by the pulse span
    always_comb begin
        step_ang  = (sel_tgt > sel_cur) ? sel_cur + 8'd1 : sel_cur - 8'd1;
        span      = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
        step_prod = $signed({1'b0, step_ang}) * span;
    end

    // Divide the magnitude by full scale through the reciprocal
    always_comb begin
        prod_abs   = prod_reg[msc_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        recip_prod = msc_pkg::MULT_W'(prod_abs[msc_pkg::MAG_W-1:0]) *
                     msc_pkg::MULT_W'(msc_pkg::DIV_RECIP);
    end

    // Restore the sign, add the offset, saturate
    always_comb begin
        quot_signed = $signed({2'b00, quot_reg});
        if (neg_reg) begin
            quot_signed = -quot_signed;
        end
        pulse_sum = quot_signed + $signed({3'b000, pulse_min_reg});
        if (pulse_sum < 0) begin
            pulse_sat = '0;
        end else if (pulse_sum > $signed(msc_pkg::SUM_W'(4095))) begin
            pulse_sat = '1;
        end else begin
            pulse_sat = pulse_sum[msc_pkg::PULSE_W-1:0];
        end
    end

    // Decode the command request
    always_comb begin
        ack_status = msc_pkg::STATUS_OK;
        ack_wr     = 1'b0;
        ack_val    = sel_cur;
        if (!idx_ok) begin
            ack_status = msc_pkg::STATUS_BAD_INDEX;
        end else begin
            unique case (req_reg.func)
                msc_pkg::FUNC_GO_MIN: begin
                    ack_wr  = 1'b1;
                    ack_val = sel_lo;
                end
                msc_pkg::FUNC_GO_MAX: begin
                    ack_wr  = 1'b1;
                    ack_val = sel_hi;
                end
                msc_pkg::FUNC_STOP: begin
                    ack_wr  = 1'b1;
                    ack_val = sel_cur;
                end
                msc_pkg::FUNC_SET_ANGLE: begin
                    if (req_reg.angle_valid && (req_reg.target_angle >= sel_lo) &&
                        (req_reg.target_angle <= sel_hi)) begin
                        ack_wr  = 1'b1;
                        ack_val = req_reg.target_angle;
                    end else begin
                        ack_status = msc_pkg::STATUS_BAD_ANGLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Update servo angles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msc_pkg::SLOTS; i++) begin
                cur_angle_reg[i] <= msc_pkg::RESET_ANGLE[i];
                tgt_angle_reg[i] <= msc_pkg::RESET_ANGLE[i];
            end
        end else begin
            if (cmd.do_step) begin
                cur_angle_reg[idx_reg] <= step_ang;
            end
            if (cmd.do_ack && ack_wr) begin
                tgt_angle_reg[idx_reg] <= ack_val;
            end
        end
    end

    // Track the servo being worked on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            mask_reg <= '0;
        end else begin
            if (cmd.capture) begin
                idx_reg <= s_data.servo_index;
            end else if (cmd.do_scan) begin
                idx_reg  <= first_set(scan_mask);
                mask_reg <= scan_mask;
            end else if (cmd.do_emit) begin
                idx_reg  <= first_set(mask_clr);
                mask_reg <= mask_clr;
            end
        end
    end

    // Hold the request and the arithmetic stages
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.do_step) begin
            prod_reg <= step_prod;
        end
        if (cmd.do_mul) begin
            quot_reg <= recip_prod[msc_pkg::DIV_SHIFT +: msc_pkg::QUOT_W];
            neg_reg  <= prod_reg[msc_pkg::PROD_W-1];
        end
    end

    // Output register
    assign out_free = !out_valid_reg || m_ready;
    assign out_load = cmd.do_ack || cmd.do_emit;

    always_comb begin
        out_data_next = out_data_reg;
        if (cmd.do_ack) begin
            out_data_next.kind     = msc_pkg::KIND_ACK;
            out_data_next.status   = ack_status;
            out_data_next.channel  = '0;
            out_data_next.pulse_us = '0;
            out_data_next.last     = 1'b1;
        end else if (cmd.do_emit) begin
            out_data_next.kind     = msc_pkg::KIND_PULSE;
            out_data_next.status   = msc_pkg::STATUS_OK;
            out_data_next.channel  = sel_chan;
            out_data_next.pulse_us = pulse_sat;
            out_data_next.last     = (mask_clr == '0);
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Status back to the controller
    always_comb begin
        stat.in_is_cmd  = s_data.func <= msc_pkg::FUNC_SET_ANGLE;
        stat.in_is_tick = s_data.func == msc_pkg::FUNC_TICK;
        stat.scan_none  = scan_mask == '0;
        stat.out_free   = out_free;
        stat.last_move  = mask_clr == '0;
    end

`ifndef SYNTHESIS
    a_step_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_step |-> mask_reg[idx_reg])
        else $error("step on a servo that is not marked to move");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over an untaken result");

    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_ack |=> (m_valid && m_data.last && (m_data.kind == msc_pkg::KIND_ACK)))
        else $error("acknowledgement not presented as a final result");
`endif

endmodule

// ----- design/msc_ctrl.sv -----
module msc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msc_pkg::dp_stat_t   stat,
    output msc_pkg::ctrl_cmd_t  cmd
);

    msc_pkg::state_t state_reg;
    msc_pkg::state_t state_next;

    // Sequence one request at a time
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            msc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (stat.in_is_cmd) begin
                        state_next = msc_pkg::ST_ACK;
                    end else if (stat.in_is_tick) begin
                        state_next = msc_pkg::ST_SCAN;
                    end
                end
            end
            msc_pkg::ST_ACK: begin
                if (stat.out_free) begin
                    cmd.do_ack = 1'b1;
                    state_next = msc_pkg::ST_IDLE;
                end
            end
            msc_pkg::ST_SCAN: begin
                cmd.do_scan = 1'b1;
                state_next  = stat.scan_none ? msc_pkg::ST_IDLE : msc_pkg::ST_STEP;
            end
            msc_pkg::ST_STEP: begin
                cmd.do_step = 1'b1;
                state_next  = msc_pkg::ST_MUL;
            end
            msc_pkg::ST_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = msc_pkg::ST_EMIT;
            end
            msc_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.do_emit = 1'b1;
                    state_next  = stat.last_move ? msc_pkg::ST_IDLE : msc_pkg::ST_STEP;
                end
            end
            default: begin
                state_next = msc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_tick_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && stat.in_is_tick) |=> (state_reg == msc_pkg::ST_SCAN))
        else $error("tick request did not start a scan");

    a_step_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msc_pkg::ST_STEP) |=> (state_reg == msc_pkg::ST_MUL))
        else $error("step not followed by the divide stage");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == msc_pkg::ST_EMIT) && stat.out_free && stat.last_move) |=> s_ready)
        else $error("final pulse update did not free the input");
`endif

endmodule
